// ===== rtl/tdpt_pkg.sv =====
package tdpt_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIVIDE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic start;
	} rem_ctrl_t;

	typedef struct packed {
		logic done;
		logic zero;
	} rem_stat_t;

endpackage

// ===== rtl/tdpt_rem.sv =====
// Restoring remainder unit, one dividend bit per cycle.
module tdpt_rem
	import tdpt_pkg::*;
#(
	parameter int W = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  rem_ctrl_t    ctrl,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output rem_stat_t    stat
);

	localparam int CNT_W = $clog2(W + 1);

	logic [W-1:0]     sh_q;
	logic [W-1:0]     rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [W:0] r2;
	logic [W:0] diff;
	logic       ge;

	assign r2   = {rem_q, sh_q[W-1]};
	assign ge   = r2 >= {1'b0, divisor};
	assign diff = r2 - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			sh_q  <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			sh_q  <= {sh_q[W-2:0], 1'b0};
			rem_q <= ge ? diff[W-1:0] : r2[W-1:0];
		end
	end

	assign stat.done = done_q;
	assign stat.zero = (rem_q == '0);

endmodule

// ===== rtl/trial_division_prime_test.sv =====
// Trial divisors run 2 .. floor(sqrt(n)); each one takes a pass through ST_CHECK and
// one bit-serial run of the remainder unit, and every number ends in ST_DONE.
// One number in flight; the bit-serial remainder unit sets the time per divisor.
// Throughput: one transfer per test; the next number is taken once the result is registered.
// Reset (arst_n, async, active low) clears the controller and output valid.
module trial_division_prime_test
	import tdpt_pkg::*;
#(
	parameter int NUMBER_WIDTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((NUMBER_WIDTH + 7) / 8)*8-1:0] s_tdata,  // number
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [((NUMBER_WIDTH + 7) / 8)*8-1:0] m_tdata,  // number_echo
	output logic                                  m_tuser   // is_prime
);

	localparam int W      = NUMBER_WIDTH;
	localparam int DATA_W = ((NUMBER_WIDTH + 7) / 8) * 8;

	state_t state_q, state_d;

	logic [W-1:0] num_q;
	logic [W-1:0] div_q;
	logic [W:0]   sq_q;
	logic         prime_q;
	logic         m_tvalid_q;
	logic [W-1:0] echo_q;
	logic         flag_q;

	rem_ctrl_t rctrl;
	rem_stat_t rstat;

	logic load_out;

	tdpt_rem #(.W(W)) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (rctrl),
		.dividend (num_q),
		.divisor  (div_q),
		.stat     (rstat)
	);

	always_comb begin
		state_d     = state_q;
		s_tready    = 1'b0;
		rctrl.start = 1'b0;
		load_out    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (num_q < W'(2) || sq_q > {1'b0, num_q}) begin
					state_d = ST_DONE;
				end else begin
					rctrl.start = 1'b1;
					state_d     = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (rstat.done) state_d = rstat.zero ? ST_DONE : ST_CHECK;
			end
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	// sq_q tracks div_q squared: (d+1)^2 = d^2 + 2d + 1
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			num_q <= s_tdata[W-1:0];
			div_q <= W'(2);
			sq_q  <= (W + 1)'(4);
		end
		if (state_q == ST_CHECK) begin
			if (num_q < W'(2)) prime_q <= 1'b0;
			else if (sq_q > {1'b0, num_q}) prime_q <= 1'b1;
		end
		if (state_q == ST_DIVIDE && rstat.done) begin
			if (rstat.zero) begin
				prime_q <= 1'b0;
			end else begin
				div_q <= div_q + 1'b1;
				sq_q  <= sq_q + {div_q, 1'b1};
			end
		end
		if (load_out) begin
			echo_q <= num_q;
			flag_q <= prime_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = DATA_W'(echo_q);
	assign m_tuser  = flag_q;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import tdpt_pkg::*;

	localparam int NUMBER_WIDTH = 16;
	localparam int TDATA_W      = ((NUMBER_WIDTH + 7) / 8) * 8;
	localparam logic [NUMBER_WIDTH-1:0] TOP_PRIME = 16'd65521;

	typedef struct packed {
		logic [NUMBER_WIDTH-1:0] number;
		logic                    is_prime;
	} verdict_t;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata;   // number
	logic               m_tvalid;
	logic               m_tready;
	logic [TDATA_W-1:0] m_tdata;   // number_echo
	logic               m_tuser;   // is_prime

	verdict_t    pending_verdicts[$];
	logic        idle_en;
	int unsigned mismatch_count;
	int unsigned error_count;

	trial_division_prime_test #(
		.NUMBER_WIDTH(NUMBER_WIDTH)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// primality by trial division, stopping once the divisor squared passes n
	function automatic logic trial_divide_verdict(logic [NUMBER_WIDTH-1:0] n);
		int unsigned d;
		if (n < 2)
			return 1'b0;
		for (d = 2; d * d <= n; d++) begin
			if (n % d == 0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic logic [NUMBER_WIDTH-1:0] prime_at_or_above(int unsigned start);
		int unsigned n;
		n = start;
		while (n <= TOP_PRIME) begin
			if (trial_divide_verdict(n[NUMBER_WIDTH-1:0]))
				return n[NUMBER_WIDTH-1:0];
			n++;
		end
		return TOP_PRIME;
	endfunction

	task automatic send_number(input logic [NUMBER_WIDTH-1:0] n);
		verdict_t v;
		@(negedge clk);
		if (idle_en && $urandom_range(0, 99) < 10) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= TDATA_W'(n);
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		v.number   = n;
		v.is_prime = trial_divide_verdict(n);
		pending_verdicts.push_back(v);
	endtask

	task automatic stop_sending();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_verdicts.size() != 0)
			@(posedge clk);
	endtask

	// receiver side: random back-pressure
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready <= !(idle_en && $urandom_range(0, 99) < 10);
		end
	end

	// result checker
	initial begin
		verdict_t exp_v;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				if (pending_verdicts.size() == 0) begin
					if (mismatch_count < 10)
						$display("unexpected result: number %0d is_prime %0b",
							m_tdata[NUMBER_WIDTH-1:0], m_tuser);
					mismatch_count++;
					error_count++;
				end else begin
					exp_v = pending_verdicts.pop_front();
					if (m_tdata[NUMBER_WIDTH-1:0] !== exp_v.number ||
						m_tuser !== exp_v.is_prime) begin
						if (mismatch_count < 10)
							$display("mismatch: exp number %0d is_prime %0b, got number %0d is_prime %0b",
								exp_v.number, exp_v.is_prime,
								m_tdata[NUMBER_WIDTH-1:0], m_tuser);
						mismatch_count++;
						error_count++;
					end
				end
			end
		end
	end

	// corner values: below two, smallest primes, powers of two, prime squares, top of range
	task automatic test_corner_values();
		logic [NUMBER_WIDTH-1:0] corners[$];
		corners = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd9, 16'd25, 16'd49,
			16'd32768, 16'd32749, 16'd63001, 16'd65025, 16'd64009, 16'hAAAA,
			16'h5555, 16'hFFFF, 16'hFFFE, TOP_PRIME, 16'd65519};
		foreach (corners[i])
			send_number(corners[i]);
	endtask

	// each number's result must come back before the next goes in
	task automatic test_one_at_a_time();
		repeat (6) begin
			send_number($urandom_range(0, 65535));
			stop_sending();
			wait_drained();
		end
	endtask

	// random mix, weighted towards primes and hard composites
	task automatic test_random_mix(input int unsigned count);
		logic [NUMBER_WIDTH-1:0] p;
		logic [NUMBER_WIDTH-1:0] q;
		repeat (count) begin
			case ($urandom_range(0, 4))
				0: send_number($urandom_range(0, 65535));
				1: send_number(prime_at_or_above($urandom_range(0, 65535)));
				2: begin
					p = prime_at_or_above($urandom_range(2, 251));
					send_number(p * p);
				end
				3: begin
					// product of two primes, the smaller the first prime at or above a draw from 2 .. 200
					p = prime_at_or_above($urandom_range(2, 200));
					q = prime_at_or_above($urandom_range(p, 65535 / p));
					send_number(p * q);
				end
				default: send_number($urandom_range(0, 255));
			endcase
		end
	endtask

	task automatic test_back_to_back();
		idle_en = 1'b0;
		repeat (15)
			send_number($urandom_range(0, 65535));
		idle_en = 1'b1;
	endtask

	initial begin
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		idle_en        = 1'b1;
		mismatch_count = 0;
		error_count    = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_corner_values();
		test_one_at_a_time();
		test_random_mix(100);
		test_back_to_back();
		stop_sending();

		wait_drained();
		repeat (50) @(posedge clk);
		error_count += pending_verdicts.size();
		if (error_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	initial begin
		#30_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

endmodule
